// ===== hdl/tkfr_pkg.sv =====
// Shared types and defaults for the top-k frequency ranker.
package tkfr_pkg;

	localparam int unsigned RankDepthDef  = 32;
	localparam int unsigned IdWidthDef    = 16;
	localparam int unsigned CountWidthDef = 24;
	localparam int unsigned ActionWidth   = 2;

	// Input action codes
	typedef enum logic [ActionWidth-1:0] {
		ACT_OFFER = 2'd0,
		ACT_DUMP  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	// Command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_OFFER,
		CELL_ROTATE,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

endpackage

// ===== hdl/tkfr_in_if.sv =====
// Input channel: action, entry id and entry count.
interface tkfr_in_if
	import tkfr_pkg::*;
#(
	parameter int unsigned ID_WIDTH    = IdWidthDef,
	parameter int unsigned COUNT_WIDTH = CountWidthDef
);
	logic                   valid;
	logic                   ready;
	logic [ActionWidth-1:0] action;
	logic [ID_WIDTH-1:0]    entry_id;
	logic [COUNT_WIDTH-1:0] entry_count;

	modport source (output valid, action, entry_id, entry_count, input ready);
	modport sink   (input valid, action, entry_id, entry_count, output ready);
endinterface

// ===== hdl/tkfr_out_if.sv =====
// Output channel: one ranked slot per transfer.
interface tkfr_out_if
	import tkfr_pkg::*;
#(
	parameter int unsigned RANK_WIDTH  = 5,
	parameter int unsigned ID_WIDTH    = IdWidthDef,
	parameter int unsigned COUNT_WIDTH = CountWidthDef
);
	logic                   valid;
	logic                   ready;
	logic [RANK_WIDTH-1:0]  rank_position;
	logic                   slot_filled;
	logic [ID_WIDTH-1:0]    ranked_id;
	logic [COUNT_WIDTH-1:0] ranked_count;
	logic                   last_of_dump;

	modport source (output valid, rank_position, slot_filled, ranked_id, ranked_count,
		last_of_dump, input ready);
	modport sink   (input valid, rank_position, slot_filled, ranked_id, ranked_count,
		last_of_dump, output ready);
endinterface

// ===== hdl/tkfr_cell.sv =====
// One rank slot of the compare-and-shift chain.
module tkfr_cell
	import tkfr_pkg::*;
#(
	parameter int unsigned ID_WIDTH    = IdWidthDef,
	parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_ctrl_t             ctrl,
	input  logic [ID_WIDTH-1:0]    new_id,
	input  logic [COUNT_WIDTH-1:0] new_count,
	input  logic                   prev_take,
	input  logic                   prev_valid,
	input  logic [ID_WIDTH-1:0]    prev_id,
	input  logic [COUNT_WIDTH-1:0] prev_count,
	input  logic                   next_valid,
	input  logic [ID_WIDTH-1:0]    next_id,
	input  logic [COUNT_WIDTH-1:0] next_count,
	output logic                   take,
	output logic                   valid,
	output logic [ID_WIDTH-1:0]    id,
	output logic [COUNT_WIDTH-1:0] count
);
	logic                   valid_q;
	logic [ID_WIDTH-1:0]    id_q;
	logic [COUNT_WIDTH-1:0] count_q;

	// slot gives way to an empty place or a strictly smaller count
	assign take  = !valid_q || (new_count > count_q);
	assign valid = valid_q;
	assign id    = id_q;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				CELL_OFFER: begin
					if (take && !prev_take) begin
						valid_q <= 1'b1;
					end else if (take) begin
						valid_q <= prev_valid;
					end
				end
				CELL_ROTATE: valid_q <= next_valid;
				CELL_CLEAR:  valid_q <= 1'b0;
				default:     valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_OFFER: begin
				if (take && !prev_take) begin
					id_q    <= new_id;
					count_q <= new_count;
				end else if (take) begin
					id_q    <= prev_id;
					count_q <= prev_count;
				end
			end
			CELL_ROTATE: begin
				id_q    <= next_id;
				count_q <= next_count;
			end
			default: begin
				id_q    <= id_q;
				count_q <= count_q;
			end
		endcase
	end

endmodule

// ===== hdl/top_k_frequency_ranker_top.sv =====
// Top level of the top-k frequency ranker: chain of rank cells and dump output.
//
// Usage:
//   in_ch carries one command per transfer: offer (entry_id, entry_count),
//   dump, or clear. out_ch returns ranked slots, produced by a dump only.
//   An offer enters the chain the cycle after its transfer; offers and clears
//   are taken back to back at one per cycle with no result, unless a dump runs.
//   A dump drives RANK_DEPTH transfers on out_ch, rank 0 first, the final
//   one marked with last_of_dump. The dump transfer starts the dump
//   sequencer, which then loads the first slot into the output register,
//   from where it is offered on out_ch. With out_ch.ready held high one
//   slot leaves per cycle; the rate is set by the chain rotating one slot
//   per cycle past the output register.
//   in_ch.ready stays low after the dump transfer until the last slot has
//   been loaded into the output register.
//   When out_ch stalls, the output register holds its slot and the chain
//   stops rotating, so nothing is lost or repeated.
//   Reset empties the list and drops any dump in progress.
module top_k_frequency_ranker_top
	import tkfr_pkg::*;
#(
	parameter int unsigned RANK_DEPTH  = RankDepthDef,
	parameter int unsigned ID_WIDTH    = IdWidthDef,
	parameter int unsigned COUNT_WIDTH = CountWidthDef,
	localparam int unsigned RANK_W     = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1
) (
	input  logic       clk,
	input  logic       arst_n,
	tkfr_in_if.sink    in_ch,
	tkfr_out_if.source out_ch
);
	// chain wiring
	logic [RANK_DEPTH-1:0]  c_take;
	logic [RANK_DEPTH-1:0]  c_valid;
	logic [ID_WIDTH-1:0]    c_id    [RANK_DEPTH];
	logic [COUNT_WIDTH-1:0] c_count [RANK_DEPTH];
	logic [RANK_DEPTH-1:0]  p_take;
	logic [RANK_DEPTH-1:0]  p_valid;
	logic [ID_WIDTH-1:0]    p_id    [RANK_DEPTH];
	logic [COUNT_WIDTH-1:0] p_count [RANK_DEPTH];

	// control
	cell_ctrl_t  ctrl;
	action_t     act;
	logic        in_xfer;
	logic        emit;
	logic        dump_last;
	logic        dump_busy_q;
	logic [RANK_W-1:0] dump_idx_q;

	// output register
	logic                   out_valid_q;
	logic [RANK_W-1:0]      out_rank_q;
	logic                   out_filled_q;
	logic [ID_WIDTH-1:0]    out_id_q;
	logic [COUNT_WIDTH-1:0] out_count_q;
	logic                   out_last_q;

	assign act       = action_t'(in_ch.action);
	assign in_ch.ready = !dump_busy_q;
	assign in_xfer   = in_ch.valid && in_ch.ready;
	// during a dump, load the output register whenever it is empty or being drained
	assign emit      = dump_busy_q && (!out_valid_q || out_ch.ready);
	assign dump_last = (dump_idx_q == RANK_W'(RANK_DEPTH - 1));

	// Broadcast one command to the chain: rotate on each emitted slot during a dump,
	// otherwise apply the accepted offer or clear.
	always_comb begin
		ctrl.op = CELL_HOLD;
		if (dump_busy_q) begin
			if (emit) begin
				ctrl.op = CELL_ROTATE;
			end
		end else if (in_xfer) begin
			unique case (act)
				ACT_OFFER: ctrl.op = CELL_OFFER;
				ACT_CLEAR: ctrl.op = CELL_CLEAR;
				default:   ctrl.op = CELL_HOLD;
			endcase
		end
	end

	// Cell i shifts from cell i-1 on an offer and takes cell i+1 on a rotate;
	// the top cell wraps around to cell 0 so a full dump restores the list.
	for (genvar i = 0; i < RANK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign p_take[i]  = 1'b0;
			assign p_valid[i] = 1'b0;
			assign p_id[i]    = '0;
			assign p_count[i] = '0;
		end else begin : g_body
			assign p_take[i]  = c_take[i-1];
			assign p_valid[i] = c_valid[i-1];
			assign p_id[i]    = c_id[i-1];
			assign p_count[i] = c_count[i-1];
		end

		tkfr_cell #(
			.ID_WIDTH   (ID_WIDTH),
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_id    (in_ch.entry_id),
			.new_count (in_ch.entry_count),
			.prev_take (p_take[i]),
			.prev_valid(p_valid[i]),
			.prev_id   (p_id[i]),
			.prev_count(p_count[i]),
			.next_valid(c_valid[(i + 1) % RANK_DEPTH]),
			.next_id   (c_id[(i + 1) % RANK_DEPTH]),
			.next_count(c_count[(i + 1) % RANK_DEPTH]),
			.take      (c_take[i]),
			.valid     (c_valid[i]),
			.id        (c_id[i]),
			.count     (c_count[i])
		);
	end

	// Dump sequencer: start on a dump transfer, advance on every emitted slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_busy_q <= 1'b0;
			dump_idx_q  <= '0;
		end else if (!dump_busy_q) begin
			if (in_xfer && act == ACT_DUMP) begin
				dump_busy_q <= 1'b1;
				dump_idx_q  <= '0;
			end
		end else if (emit) begin
			dump_idx_q <= dump_idx_q + 1'b1;
			if (dump_last) begin
				dump_busy_q <= 1'b0;
			end
		end
	end

	// Output valid: set by each emitted slot, dropped once the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: cell 0 always holds the next slot of the dump.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_rank_q   <= dump_idx_q;
			out_filled_q <= c_valid[0];
			out_id_q     <= c_valid[0] ? c_id[0] : '0;
			out_count_q  <= c_valid[0] ? c_count[0] : '0;
			out_last_q   <= dump_last;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.rank_position = out_rank_q;
	assign out_ch.slot_filled   = out_filled_q;
	assign out_ch.ranked_id     = out_id_q;
	assign out_ch.ranked_count  = out_count_q;
	assign out_ch.last_of_dump  = out_last_q;

	// Invariant checks on the list outside a dump
	logic [RANK_DEPTH-1:0] valid_inc;
	logic [RANK_DEPTH-1:0] order_ok;

	assign valid_inc = c_valid + 1'b1;

	for (genvar i = 0; i < RANK_DEPTH; i++) begin : g_order
		if (i == RANK_DEPTH - 1) begin : g_tail
			assign order_ok[i] = 1'b1;
		end else begin : g_pair
			assign order_ok[i] = !c_valid[i+1] || (c_count[i] >= c_count[i+1]);
		end
	end

	// filled slots form an unbroken run from rank 0
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		!dump_busy_q |-> ((valid_inc & c_valid) == '0))
		else $error("filled slots are not a prefix of the list");

	// counts never increase down the list
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		!dump_busy_q |-> (&order_ok))
		else $error("ranked counts out of order");

	// the end of a dump leaves the final slot waiting in the output register
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(dump_busy_q) |-> (out_valid_q && out_last_q))
		else $error("dump ended without its final slot");

	// a dump begins the cycle after a dump transfer
	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && act == ACT_DUMP) |=> (dump_busy_q && dump_idx_q == '0))
		else $error("dump did not start");

endmodule
